>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds on every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent on the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/pwmw_pkg.sv
// ----------------------------------------------------------------------------
// Packed weight matrix walker package
// Layout codes, register indexes, request kinds and the result record.
// ----------------------------------------------------------------------------
package pwmw_pkg;

  // Packing layouts of the weight section
  localparam logic [2:0] LAYOUT_FULL       = 3'd0;
  localparam logic [2:0] LAYOUT_UPPER      = 3'd1;
  localparam logic [2:0] LAYOUT_LOWER      = 3'd2;
  localparam logic [2:0] LAYOUT_UPPER_DIAG = 3'd3;
  localparam logic [2:0] LAYOUT_LOWER_DIAG = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_LAYOUT     = 2'd0;
  localparam logic [1:0] REG_NODE_COUNT = 2'd1;
  localparam logic [1:0] REG_DROP_FIRST = 2'd2;

  // Request kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_WORD  = 1'b1;

  // Field widths of the result
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;

  // One result, last field in the lowest bits
  typedef struct packed {
    logic             complete;
    logic [IDX_W-1:0] clear_index;
    logic             clear_diag;
    logic             mirror;
    logic [VAL_W-1:0] cell_value;
    logic [IDX_W-1:0] cell_col;
    logic [IDX_W-1:0] cell_row;
    logic             write_valid;
  } result_t;

endpackage

>>> rtl/pwmw_skid.sv
// ----------------------------------------------------------------------------
// Output skid buffer
// Two-entry result register that keeps the upstream side free of the
// downstream ready path.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwmw_skid #(
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              skid_valid;
  logic [DATA_W-1:0] skid_data;
  logic              pop;

  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;

  // Hold, advance or park the result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid || pop) begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_IMPLY(a_skid_needs_out, clk, rst, skid_valid, out_valid, "skid full, output empty")
  `ASSERT_NEXT(a_park_on_stall, clk, rst, in_valid && in_ready && out_valid && !out_ready, skid_valid, "stalled request not parked")
  `ASSERT_NEXT(a_drain_skid, clk, rst, skid_valid && pop, !skid_valid && out_valid, "skid entry lost on drain")

endmodule

>>> rtl/packed_weight_matrix_walker.sv
// ----------------------------------------------------------------------------
// Packed weight matrix walker
// Walks a packed edge-weight section (full matrix or triangle, with or
// without diagonal) and gives per word the cell to write, its mirror flag
// and any diagonal cell to clear.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | contents
//  s_*      | in  | s_tvalid/s_tready  | tdata: weight, line_start; tuser: kind
//  m_*      | out | m_tvalid/m_tready  | tdata: cell write fields; tlast: complete
//  cfg_*    | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// One request per cycle while s_tready is high. The accepting edge updates the
// walk state and registers the result; m_tvalid shows it from the next cycle
// unless the downstream stalls, when a two-entry output buffer takes one more
// result; s_tready drops only when both entries are full.
// rst is synchronous and resets the registers, the walk state and the buffer.
// Start events and dropped words give no result except the (0,0) clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packed_weight_matrix_walker #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // weight[31:0], line_start[32], zero pad
  input  logic [0:0]  s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // write_valid[0], cell_row[10:1], cell_col[20:11],
                                 // cell_value[52:21], mirror[53], clear_diag[54],
                                 // clear_index[64:55], zero pad
  output logic        m_tlast,   // complete
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int POS_W  = $clog2(MAX_NODES + 2);
  localparam int WL_W   = 2 * POS_W;
  localparam int PROD_W = 2 * POS_W + 1;
  localparam int WV_W   = (WEIGHT_BITS < pwmw_pkg::VAL_W) ? WEIGHT_BITS : pwmw_pkg::VAL_W;

  // Configuration registers
  logic [2:0]  layout;
  logic [10:0] node_count;
  logic        drop_first_line;

  // Walk state
  logic [POS_W-1:0] row_pos, row_pos_next;
  logic [POS_W-1:0] col_pos, col_pos_next;
  logic [WL_W-1:0]  words_left, words_left_next;
  logic             first_line_pending, first_line_pending_next;
  logic             dropping_line, dropping_line_next;

  logic             accept;
  logic             line_start;
  logic [31:0]      node_count_ext;
  logic [POS_W-1:0] n_eff;
  logic [POS_W:0]   mult_a;
  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0] col_inc;
  logic [POS_W-1:0] row_inc;
  logic [31:0]      row_ext, col_ext, clr_ext;
  logic [POS_W-1:0] clr;
  logic             do_clear;
  logic             walk;
  logic             res_valid;
  pwmw_pkg::result_t res;
  pwmw_pkg::result_t out_res;
  logic [pwmw_pkg::VAL_W-1:0] value;

  assign accept     = s_tvalid && s_tready;
  assign line_start = s_tdata[32];

  // Clamp the node count into 1..MAX_NODES
  always_comb begin
    node_count_ext = 32'(node_count);
    if (node_count_ext == 32'd0) begin
      n_eff = POS_W'(1);
    end else if (node_count_ext > 32'(MAX_NODES)) begin
      n_eff = POS_W'(MAX_NODES);
    end else begin
      n_eff = POS_W'(node_count_ext);
    end
  end

  // Section size: n*n, n(n-1)/2 or n(n+1)/2
  always_comb begin
    priority if (layout == pwmw_pkg::LAYOUT_UPPER || layout == pwmw_pkg::LAYOUT_LOWER) begin
      mult_a = (POS_W + 1)'(n_eff) - (POS_W + 1)'(1);
    end else if (layout == pwmw_pkg::LAYOUT_UPPER_DIAG ||
                 layout == pwmw_pkg::LAYOUT_LOWER_DIAG) begin
      mult_a = (POS_W + 1)'(n_eff) + (POS_W + 1)'(1);
    end else begin
      mult_a = (POS_W + 1)'(n_eff);
    end
    prod = PROD_W'(mult_a) * PROD_W'(n_eff);
  end

  // Sign-extend the low weight bits
  always_comb begin
    for (int i = 0; i < pwmw_pkg::VAL_W; i++) begin
      value[i] = (i < WV_W) ? s_tdata[i] : s_tdata[WV_W-1];
    end
  end

  assign col_inc = col_pos + POS_W'(1);
  assign row_inc = row_pos + POS_W'(1);
  assign row_ext = 32'(row_pos);
  assign col_ext = 32'(col_pos);

  // Next walk state and the result of this request
  always_comb begin
    row_pos_next            = row_pos;
    col_pos_next            = col_pos;
    words_left_next         = words_left;
    first_line_pending_next = first_line_pending;
    dropping_line_next      = dropping_line;
    res_valid               = 1'b0;
    res                     = '0;
    do_clear                = 1'b0;
    clr                     = '0;
    clr_ext                 = '0;
    walk                    = 1'b0;

    if (s_tuser[0] == pwmw_pkg::KIND_START) begin
      row_pos_next            = '0;
      col_pos_next            = '0;
      first_line_pending_next = 1'b0;
      dropping_line_next      = 1'b0;
      unique case (layout)
        pwmw_pkg::LAYOUT_FULL: begin
          words_left_next         = WL_W'(prod);
          first_line_pending_next = drop_first_line;
        end
        pwmw_pkg::LAYOUT_UPPER, pwmw_pkg::LAYOUT_LOWER: begin
          if (layout == pwmw_pkg::LAYOUT_UPPER) begin
            col_pos_next = POS_W'(1);
          end else begin
            row_pos_next = POS_W'(1);
          end
          words_left_next = WL_W'(prod >> 1);
          res_valid       = 1'b1;
          res.clear_diag  = 1'b1;
        end
        pwmw_pkg::LAYOUT_UPPER_DIAG, pwmw_pkg::LAYOUT_LOWER_DIAG: begin
          words_left_next = WL_W'(prod >> 1);
        end
        default: begin
          words_left_next = '0;
        end
      endcase
    end else begin
      walk = 1'b1;
      // Skip the size line of a full matrix
      if (layout == pwmw_pkg::LAYOUT_FULL) begin
        if (first_line_pending) begin
          first_line_pending_next = 1'b0;
          dropping_line_next      = 1'b1;
          walk                    = 1'b0;
        end else if (dropping_line) begin
          if (!line_start) begin
            walk = 1'b0;
          end else begin
            dropping_line_next = 1'b0;
          end
        end
      end

      if (walk && (words_left == '0 || layout > pwmw_pkg::LAYOUT_LOWER_DIAG)) begin
        walk = 1'b0;
      end

      // Position outside the current matrix ends the section
      if (walk && (row_pos >= n_eff || col_pos >= n_eff)) begin
        walk            = 1'b0;
        words_left_next = '0;
      end

      if (walk) begin
        col_pos_next = col_inc;
        unique case (layout)
          pwmw_pkg::LAYOUT_FULL: begin
            if (col_inc >= n_eff) begin
              col_pos_next = '0;
              row_pos_next = row_inc;
            end
          end
          pwmw_pkg::LAYOUT_UPPER: begin
            if (col_inc >= n_eff) begin
              row_pos_next = row_inc;
              col_pos_next = row_inc + POS_W'(1);
              if (row_inc < n_eff) begin
                do_clear = 1'b1;
                clr      = row_inc;
              end
            end
          end
          pwmw_pkg::LAYOUT_LOWER: begin
            if (col_inc >= row_pos) begin
              col_pos_next = '0;
              row_pos_next = row_inc;
              if (col_inc < n_eff) begin
                do_clear = 1'b1;
                clr      = col_inc;
              end
            end
          end
          pwmw_pkg::LAYOUT_UPPER_DIAG: begin
            if (col_inc >= n_eff) begin
              row_pos_next = row_inc;
              col_pos_next = row_inc;
            end
          end
          default: begin
            if (col_inc > row_pos) begin
              col_pos_next = '0;
              row_pos_next = row_inc;
            end
          end
        endcase
        words_left_next = words_left - WL_W'(1);
        clr_ext         = 32'(clr);

        res_valid       = 1'b1;
        res.write_valid = 1'b1;
        res.cell_row    = row_ext[pwmw_pkg::IDX_W-1:0];
        res.cell_col    = col_ext[pwmw_pkg::IDX_W-1:0];
        res.cell_value  = value;
        res.mirror      = (layout != pwmw_pkg::LAYOUT_FULL);
        res.clear_diag  = do_clear;
        res.clear_index = do_clear ? clr_ext[pwmw_pkg::IDX_W-1:0] : '0;
        res.complete    = (words_left == WL_W'(1));
      end
    end
  end

  // Configuration writes and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      layout             <= pwmw_pkg::LAYOUT_FULL;
      node_count         <= 11'd1;
      drop_first_line    <= 1'b0;
      row_pos            <= '0;
      col_pos            <= '0;
      words_left         <= '0;
      first_line_pending <= 1'b0;
      dropping_line      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pwmw_pkg::REG_LAYOUT:     layout          <= cfg_data[2:0];
          pwmw_pkg::REG_NODE_COUNT: node_count      <= cfg_data;
          pwmw_pkg::REG_DROP_FIRST: drop_first_line <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        row_pos            <= row_pos_next;
        col_pos            <= col_pos_next;
        words_left         <= words_left_next;
        first_line_pending <= first_line_pending_next;
        dropping_line      <= dropping_line_next;
      end
    end
  end

  // Result buffer
  pwmw_skid #(
    .DATA_W($bits(pwmw_pkg::result_t))
  ) u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept && res_valid),
    .in_ready (s_tready),
    .in_data  (res),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_res)
  );

  assign m_tdata = {7'd0, out_res.clear_index, out_res.clear_diag, out_res.mirror,
                    out_res.cell_value, out_res.cell_col, out_res.cell_row,
                    out_res.write_valid};
  assign m_tlast = out_res.complete;

  `ASSERT_NEXT(a_complete_empties, clk, rst, accept && res_valid && res.complete, words_left == '0, "complete left words pending")
  `ASSERT_IMPLY(a_clear_only_result, clk, rst, accept && res_valid && !res.write_valid, res.clear_diag, "empty result")
  `ASSERT_IMPLY(a_mirror_layout, clk, rst, accept && res.write_valid, res.mirror == (layout != pwmw_pkg::LAYOUT_FULL), "mirror flag does not match layout")

endmodule

>>> test/tb_packed_weight_matrix_walker.sv
// ----------------------------------------------------------------------------
// Packed weight matrix walker testbench
// Drives start events and weight words into the walker under every layout,
// node counts from the clamped low end to the clamped high end and the
// first-line drop. A table of directed requests runs first, then phases of
// random sections with random content. A behavioral walk in the bench
// predicts every cell write, mirror flag, diagonal clear and completion.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_packed_weight_matrix_walker;

  // Codes the package leaves unnamed
  localparam logic [2:0]  LAYOUT_SPARE = 3'd5;
  localparam logic [1:0]  REG_SPARE    = 2'd3;
  localparam logic [10:0] NODES_MAX    = 11'd1024;

  localparam logic [31:0] W_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN  = 32'h8000_0000;
  localparam logic [31:0] W_ONES = 32'hFFFF_FFFF;

  localparam int RANDOM_ITEMS = 1800;
  localparam int IDLE_LIMIT   = 2000;

  // One row of the directed table: a register write or a request
  typedef struct {
    bit                is_reg;
    logic [1:0]        reg_index;
    logic [10:0]       reg_value;
    logic              kind;
    logic [31:0]       weight;
    logic              line_start;
    bit                typed;
    bit                typed_hit;
    pwmw_pkg::result_t typed_res;
  } plan_row_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;  // weight[31:0], line_start[32], zero pad
  logic [0:0]  s_tuser   = '0;  // kind[0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [71:0] m_tdata;         // write_valid[0], cell_row[10:1], cell_col[20:11],
                                // cell_value[52:21], mirror[53], clear_diag[54],
                                // clear_index[64:55], zero pad
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data  = '0;

  // Register copies and walk state of the predictor
  logic [2:0]  reg_layout = pwmw_pkg::LAYOUT_FULL;
  logic [10:0] reg_nodes  = 11'd1;
  logic        reg_drop   = 1'b0;
  logic [10:0] walk_row   = '0;
  logic [10:0] walk_col   = '0;
  logic [20:0] words_left = '0;
  logic        skip_pending  = 1'b0;
  logic        skipping_line = 1'b0;

  pwmw_pkg::result_t pending_writes[$];
  plan_row_t         plan[$];
  bit      calm = 1'b0;
  int      errors = 0;
  int      results_seen = 0;
  int      requests_taken = 0;
  int      starts_taken = 0;
  int      reg_writes = 0;
  int      idle_cycles = 0;

  packed_weight_matrix_walker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic pwmw_pkg::result_t res(logic wv, logic [9:0] row, logic [9:0] col,
                                            logic [31:0] val, logic mir, logic clr,
                                            logic [9:0] ci, logic cmp);
    pwmw_pkg::result_t r;
    r.write_valid = wv;
    r.cell_row    = row;
    r.cell_col    = col;
    r.cell_value  = val;
    r.mirror      = mir;
    r.clear_diag  = clr;
    r.clear_index = ci;
    r.complete    = cmp;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, logic [10:0] val);
    plan_row_t p;
    p = '{default: '0};
    p.is_reg    = 1'b1;
    p.reg_index = idx;
    p.reg_value = val;
    return p;
  endfunction

  function automatic plan_row_t req_row(logic k, logic [31:0] w, logic ls);
    plan_row_t p;
    p = '{default: '0};
    p.kind       = k;
    p.weight     = w;
    p.line_start = ls;
    return p;
  endfunction

  // Request whose outcome is no result at all
  function automatic plan_row_t req_none(logic k, logic [31:0] w, logic ls);
    plan_row_t p;
    p = req_row(k, w, ls);
    p.typed = 1'b1;
    return p;
  endfunction

  function automatic plan_row_t req_gives(logic k, logic [31:0] w, logic ls,
                                          pwmw_pkg::result_t r);
    plan_row_t p;
    p = req_none(k, w, ls);
    p.typed_hit = 1'b1;
    p.typed_res = r;
    return p;
  endfunction

  // Append one row to the directed table
  task automatic add_row(plan_row_t p);
    plan = {plan, p};
  endtask

  // Advance the walk by one request; return 1 when it yields a result
  function automatic bit advance_walk(input logic kind, input logic [31:0] w,
                                      input logic ls, output pwmw_pkg::result_t r);
    logic [10:0] n;
    logic [10:0] row;
    logic [10:0] col;
    logic [10:0] clr;
    bit          do_clr;
    bit          mir;
    int          nn;
    r = '0;
    n = (reg_nodes == 11'd0) ? 11'd1 : ((reg_nodes > NODES_MAX) ? NODES_MAX : reg_nodes);
    nn = int'(n);

    // Start event: rewind and size the section
    if (kind == pwmw_pkg::KIND_START) begin
      walk_row = '0;
      walk_col = '0;
      skip_pending = 1'b0;
      skipping_line = 1'b0;
      case (reg_layout)
        pwmw_pkg::LAYOUT_FULL: begin
          words_left = 21'(nn * nn);
          skip_pending = reg_drop;
        end
        pwmw_pkg::LAYOUT_UPPER, pwmw_pkg::LAYOUT_LOWER: begin
          if (reg_layout == pwmw_pkg::LAYOUT_UPPER) walk_col = 11'd1;
          else walk_row = 11'd1;
          words_left = 21'(((nn - 1) * nn) / 2);
          r.clear_diag = 1'b1;
          return 1'b1;
        end
        pwmw_pkg::LAYOUT_UPPER_DIAG, pwmw_pkg::LAYOUT_LOWER_DIAG: begin
          words_left = 21'(((nn + 1) * nn) / 2);
        end
        default: begin
          words_left = '0;
        end
      endcase
      return 1'b0;
    end

    // Drop the size line of a full matrix
    if (reg_layout == pwmw_pkg::LAYOUT_FULL) begin
      if (skip_pending) begin
        skip_pending = 1'b0;
        skipping_line = 1'b1;
        return 1'b0;
      end
      if (skipping_line) begin
        if (!ls) return 1'b0;
        skipping_line = 1'b0;
      end
    end

    if (words_left == '0 || reg_layout > pwmw_pkg::LAYOUT_LOWER_DIAG) return 1'b0;
    if (walk_row >= n || walk_col >= n) begin
      words_left = '0;
      return 1'b0;
    end

    row = walk_row;
    col = walk_col;
    walk_col = col + 11'd1;
    mir = 1'b1;
    do_clr = 1'b0;
    clr = '0;
    case (reg_layout)
      pwmw_pkg::LAYOUT_FULL: begin
        mir = 1'b0;
        if (walk_col >= n) begin
          walk_col = '0;
          walk_row = row + 11'd1;
        end
      end
      pwmw_pkg::LAYOUT_UPPER: begin
        if (walk_col >= n) begin
          walk_row = row + 11'd1;
          if (walk_row < n) begin
            do_clr = 1'b1;
            clr = walk_row;
          end
          walk_col = walk_row + 11'd1;
        end
      end
      pwmw_pkg::LAYOUT_LOWER: begin
        if (walk_col >= row) begin
          if (walk_col < n) begin
            do_clr = 1'b1;
            clr = walk_col;
          end
          walk_col = '0;
          walk_row = row + 11'd1;
        end
      end
      pwmw_pkg::LAYOUT_UPPER_DIAG: begin
        if (walk_col >= n) begin
          walk_row = row + 11'd1;
          walk_col = walk_row;
        end
      end
      default: begin
        if (walk_col > row) begin
          walk_col = '0;
          walk_row = row + 11'd1;
        end
      end
    endcase
    words_left = words_left - 21'd1;

    r = res(1'b1, row[9:0], col[9:0], w, mir, do_clr, do_clr ? clr[9:0] : 10'd0,
            words_left == '0);
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 11))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return W_ONES;
      default: return $urandom;
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
    errors++;
  endtask

  task automatic check_result(pwmw_pkg::result_t got, pwmw_pkg::result_t want);
    if (got.write_valid !== want.write_valid)
      note_mismatch($sformatf("write_valid %0b, want %0b", got.write_valid,
                              want.write_valid));
    if (got.cell_row !== want.cell_row)
      note_mismatch($sformatf("cell_row %0d, want %0d", got.cell_row, want.cell_row));
    if (got.cell_col !== want.cell_col)
      note_mismatch($sformatf("cell_col %0d, want %0d", got.cell_col, want.cell_col));
    if (got.cell_value !== want.cell_value)
      note_mismatch($sformatf("cell_value %h, want %h", got.cell_value,
                              want.cell_value));
    if (got.mirror !== want.mirror)
      note_mismatch($sformatf("mirror %0b, want %0b", got.mirror, want.mirror));
    if (got.clear_diag !== want.clear_diag)
      note_mismatch($sformatf("clear_diag %0b, want %0b", got.clear_diag,
                              want.clear_diag));
    if (got.clear_index !== want.clear_index)
      note_mismatch($sformatf("clear_index %0d, want %0d", got.clear_index,
                              want.clear_index));
    if (got.complete !== want.complete)
      note_mismatch($sformatf("complete %0b, want %0b", got.complete, want.complete));
  endtask

  // Present one request after a random gap and hold it until taken
  task automatic offer(input logic kind, input logic [31:0] w, input logic ls,
                       input bit typed, input bit typed_hit,
                       input pwmw_pkg::result_t typed_res);
    int unsigned       gap;
    bit                hit;
    pwmw_pkg::result_t want;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, ls, w};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    hit = advance_walk(kind, w, ls, want);
    if (typed) begin
      hit = typed_hit;
      want = typed_res;
    end
    if (hit) pending_writes = {pending_writes, want};
    requests_taken++;
    if (kind == pwmw_pkg::KIND_START) starts_taken++;
  endtask

  task automatic send_word(logic [31:0] w, logic ls);
    offer(pwmw_pkg::KIND_WORD, w, ls, 1'b0, 1'b0, '0);
  endtask

  // Drain all results, then let the block settle before touching registers
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      pwmw_pkg::REG_LAYOUT:     reg_layout = val[2:0];
      pwmw_pkg::REG_NODE_COUNT: reg_nodes = val;
      pwmw_pkg::REG_DROP_FIRST: reg_drop = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Result sink with random stalls
  initial begin
    int unsigned stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compare each taken result and watch for a hang
  always @(posedge clk) begin
    pwmw_pkg::result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = pwmw_pkg::result_t'({m_tlast, m_tdata[64:0]});
        if (pending_writes.size() == 0) note_mismatch("result with no request pending");
        else check_result(got, pending_writes.pop_front());
        results_seen++;
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    bit          in_regs;
    int          count;
    int unsigned shape;
    int unsigned pick;
    logic        ls;

    // Directed table
    add_row(req_none(pwmw_pkg::KIND_WORD, 32'd0, 1'b1));
    add_row(req_none(pwmw_pkg::KIND_START, 32'd0, 1'b0));
    add_row(req_gives(pwmw_pkg::KIND_WORD, W_MIN, 1'b0,
                      res(1'b1, 10'd0, 10'd0, W_MIN, 1'b0, 1'b0, 10'd0, 1'b1)));
    add_row(req_none(pwmw_pkg::KIND_WORD, W_MAX, 1'b1));
    // Upper triangle, three nodes: full walk plus one word too many
    add_row(reg_row(pwmw_pkg::REG_LAYOUT, 11'(pwmw_pkg::LAYOUT_UPPER)));
    add_row(reg_row(pwmw_pkg::REG_NODE_COUNT, 11'd3));
    add_row(req_gives(pwmw_pkg::KIND_START, W_MAX, 1'b1,
                      res(1'b0, 10'd0, 10'd0, '0, 1'b0, 1'b1, 10'd0, 1'b0)));
    add_row(req_row(pwmw_pkg::KIND_WORD, W_MAX, 1'b1));
    add_row(req_row(pwmw_pkg::KIND_WORD, W_ONES, 1'b0));
    add_row(req_row(pwmw_pkg::KIND_WORD, 32'd1, 1'b0));
    add_row(req_none(pwmw_pkg::KIND_WORD, W_MIN, 1'b1));
    // Lower triangle, node count zero taken as one: empty section
    add_row(reg_row(pwmw_pkg::REG_LAYOUT, 11'(pwmw_pkg::LAYOUT_LOWER)));
    add_row(reg_row(pwmw_pkg::REG_NODE_COUNT, 11'd0));
    add_row(req_gives(pwmw_pkg::KIND_START, W_ONES, 1'b0,
                      res(1'b0, 10'd0, 10'd0, '0, 1'b0, 1'b1, 10'd0, 1'b0)));
    add_row(req_none(pwmw_pkg::KIND_WORD, W_MAX, 1'b1));
    add_row(reg_row(pwmw_pkg::REG_NODE_COUNT, 11'd4));
    add_row(req_gives(pwmw_pkg::KIND_START, 32'd0, 1'b1,
                      res(1'b0, 10'd0, 10'd0, '0, 1'b0, 1'b1, 10'd0, 1'b0)));
    add_row(req_row(pwmw_pkg::KIND_WORD, 32'd5, 1'b1));
    add_row(req_row(pwmw_pkg::KIND_WORD, W_MIN, 1'b0));
    add_row(req_row(pwmw_pkg::KIND_WORD, W_MAX, 1'b1));
    // Upper with diagonal at the clamped node count, then switch layout mid walk
    add_row(reg_row(pwmw_pkg::REG_LAYOUT, 11'(pwmw_pkg::LAYOUT_UPPER_DIAG)));
    add_row(reg_row(pwmw_pkg::REG_NODE_COUNT, 11'h7FF));
    add_row(reg_row(pwmw_pkg::REG_DROP_FIRST, 11'd1));
    add_row(req_none(pwmw_pkg::KIND_START, W_MAX, 1'b0));
    add_row(req_row(pwmw_pkg::KIND_WORD, 32'd7, 1'b1));
    add_row(req_row(pwmw_pkg::KIND_WORD, W_ONES, 1'b0));
    add_row(reg_row(pwmw_pkg::REG_LAYOUT, 11'(pwmw_pkg::LAYOUT_LOWER_DIAG)));
    add_row(req_row(pwmw_pkg::KIND_WORD, 32'd9, 1'b0));
    // Full matrix with the size line dropped, then shrink below the walk
    add_row(reg_row(pwmw_pkg::REG_LAYOUT, 11'(pwmw_pkg::LAYOUT_FULL)));
    add_row(reg_row(pwmw_pkg::REG_NODE_COUNT, 11'd2));
    add_row(req_none(pwmw_pkg::KIND_START, 32'd0, 1'b1));
    add_row(req_none(pwmw_pkg::KIND_WORD, 32'd2, 1'b1));
    add_row(req_none(pwmw_pkg::KIND_WORD, W_MAX, 1'b0));
    add_row(req_row(pwmw_pkg::KIND_WORD, 32'd3, 1'b1));
    add_row(req_row(pwmw_pkg::KIND_WORD, W_MIN, 1'b0));
    add_row(reg_row(pwmw_pkg::REG_NODE_COUNT, 11'd1));
    add_row(req_none(pwmw_pkg::KIND_WORD, 32'd4, 1'b1));
    // Unknown layout and the unused register index
    add_row(reg_row(pwmw_pkg::REG_LAYOUT, 11'(LAYOUT_SPARE)));
    add_row(reg_row(REG_SPARE, 11'h7FF));
    add_row(reg_row(pwmw_pkg::REG_DROP_FIRST, 11'd0));
    add_row(req_none(pwmw_pkg::KIND_START, W_ONES, 1'b1));
    add_row(req_none(pwmw_pkg::KIND_WORD, W_ONES, 1'b1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    in_regs = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!in_regs) settle();
        in_regs = 1'b1;
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        if (in_regs) cfg_we <= 1'b0;
        in_regs = 1'b0;
        offer(plan[i].kind, plan[i].weight, plan[i].line_start, plan[i].typed,
              plan[i].typed_hit, plan[i].typed_res);
      end
    end

    // Random phases: new settings, then a section, a continuation or noise
    while (requests_taken < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 9) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)
          write_reg(pwmw_pkg::REG_LAYOUT, 11'(LAYOUT_SPARE + 3'($urandom_range(0, 2))));
        else write_reg(pwmw_pkg::REG_LAYOUT, 11'(pick % 5));
      end
      if ($urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, 29);
        if (pick == 0) write_reg(pwmw_pkg::REG_NODE_COUNT, 11'd0);
        else if (pick == 1) write_reg(pwmw_pkg::REG_NODE_COUNT, NODES_MAX);
        else if (pick == 2)
          write_reg(pwmw_pkg::REG_NODE_COUNT, 11'($urandom_range(1025, 2047)));
        else if (pick < 6) write_reg(pwmw_pkg::REG_NODE_COUNT, 11'($urandom_range(10, 40)));
        else write_reg(pwmw_pkg::REG_NODE_COUNT, 11'($urandom_range(1, 9)));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(pwmw_pkg::REG_DROP_FIRST, 11'($urandom_range(0, 1)));
      cfg_we <= 1'b0;
      calm = ($urandom_range(0, 4) == 0);
      shape = $urandom_range(0, 9);

      if (shape < 7) begin
        // Well-formed section with random content
        offer(pwmw_pkg::KIND_START, pick_weight(), 1'($urandom_range(0, 1)), 1'b0, 1'b0,
              '0);
        if (reg_layout == pwmw_pkg::LAYOUT_FULL && reg_drop) begin
          send_word(pick_weight(), $urandom_range(0, 3) != 0);
          repeat ($urandom_range(0, 2)) send_word(pick_weight(), 1'b0);
        end
        count = (words_left > 21'd48) ? 48 : int'(words_left);
        if ($urandom_range(0, 5) == 0) count = $urandom_range(0, count);
        else count += $urandom_range(0, 2);
        repeat (count) begin
          ls = (reg_layout == pwmw_pkg::LAYOUT_FULL) ? (walk_col == '0) :
                                                       1'($urandom_range(0, 1));
          if ($urandom_range(0, 7) == 0) ls = ~ls;
          send_word(pick_weight(), ls);
        end
      end else if (shape < 9) begin
        // Carry the current walk on under the new settings
        repeat ($urandom_range(1, 12)) send_word(pick_weight(), 1'($urandom_range(0, 1)));
      end else begin
        // Noise: starts and words in any order
        repeat ($urandom_range(4, 12))
          offer(($urandom_range(0, 5) == 0) ? pwmw_pkg::KIND_START : pwmw_pkg::KIND_WORD,
                pick_weight(), 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
      end
    end

    // Drain and wait out the pipeline
    calm = 1'b0;
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (pending_writes.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_writes.size()));

    $display("Covered %0d requests (%0d section starts) and %0d register writes;",
             requests_taken, starts_taken, reg_writes);
    $display("checked %0d results, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> packed_weight_matrix_walker.f
+incdir+rtl
rtl/pwmw_pkg.sv
rtl/pwmw_skid.sv
rtl/packed_weight_matrix_walker.sv
test/tb_packed_weight_matrix_walker.sv
